[rtl/sfr_pkg.sv]
// Shared widths and controller/datapath interface types for the fraction reducer.
`timescale 1ns / 1ps
`default_nettype none
package sfr_pkg;

  localparam int NUM_W = 64;
  localparam int DEN_W = 32;
  localparam int CNT_W = 7;
  localparam int K_W   = 5;

  localparam logic [CNT_W-1:0] DIV_N_STEPS = CNT_W'(NUM_W);
  localparam logic [CNT_W-1:0] DIV_D_STEPS = CNT_W'(DEN_W);

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_n_init;
    logic div_d_init;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic num_zero;
    logic gcd_done;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

[rtl/saturating_fraction_reducer.sv]
// Top level of the saturating fraction reducer.
// Reduces in_num_in / in_den_in to lowest terms; a zero denominator counts as
// one, a zero numerator gives 0/1, and a reduced numerator above 32 bits reads
// as all ones with no flag. A transaction is taken when start is high and busy
// is low; the result appears on out_num_out/out_den_out for one cycle with
// out_valid and cannot be held off, so the receiver must take it then. A zero
// numerator goes straight from the check state to the result. Otherwise the
// binary GCD loop runs first (one shift or one 64-bit subtract per cycle),
// followed by 64 steps of the shared restoring divider for the numerator and
// 32 for the denominator. A new transaction may start in the cycle that the
// result is shown.
`timescale 1ns / 1ps
`default_nettype none
module saturating_fraction_reducer (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [sfr_pkg::NUM_W-1:0] in_num_in,
  input  wire logic [sfr_pkg::DEN_W-1:0] in_den_in,
  output logic                           out_valid,
  output logic [sfr_pkg::DEN_W-1:0]      out_num_out,
  output logic [sfr_pkg::DEN_W-1:0]      out_den_out
);

  sfr_pkg::cmd_t cmd;
  sfr_pkg::sts_t sts;

  sfr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sfr_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_num    (in_num_in),
    .in_den    (in_den_in),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_num   (out_num_out),
    .out_den   (out_den_out)
  );

endmodule
`default_nettype wire

[rtl/sfr_ctrl.sv]
// Sequencing state machine for the fraction reducer.
`timescale 1ns / 1ps
`default_nettype none
module sfr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire sfr_pkg::sts_t sts,
  output sfr_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_GCD   = 3'd2;
  localparam logic [2:0] S_DIVN  = 3'd3;
  localparam logic [2:0] S_DIVD  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.num_zero) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_n_init = 1'b1;
          state_nxt      = S_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIVN: begin
        if (sts.div_done) begin
          cmd.div_d_init = 1'b1;
          state_nxt      = S_DIVD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DIVD: begin
        if (sts.div_done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

[rtl/sfr_dpath.sv]
// Datapath: binary GCD engine, shared restoring divider and result registers.
`timescale 1ns / 1ps
`default_nettype none
module sfr_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [sfr_pkg::NUM_W-1:0] in_num,
  input  wire logic [sfr_pkg::DEN_W-1:0] in_den,
  input  wire sfr_pkg::cmd_t             cmd,
  output sfr_pkg::sts_t                  sts,
  output logic                           out_valid,
  output logic [sfr_pkg::DEN_W-1:0]      out_num,
  output logic [sfr_pkg::DEN_W-1:0]      out_den
);

  localparam int NW = sfr_pkg::NUM_W;
  localparam int DW = sfr_pkg::DEN_W;

  logic [NW-1:0]             n_r;
  logic [DW-1:0]             d_r;
  logic                      nz_r;
  logic [NW-1:0]             u_r;
  logic [NW-1:0]             v_r;
  logic [sfr_pkg::K_W-1:0]   k_r;
  logic [DW-1:0]             g_r;
  logic [NW-1:0]             dq_r;
  logic [DW-1:0]             rem_r;
  logic [sfr_pkg::CNT_W-1:0] cnt_r;
  logic [DW-1:0]             qn_r;
  logic                      out_valid_r;
  logic [DW-1:0]             out_num_r;
  logic [DW-1:0]             out_den_r;

  logic [DW-1:0] den_adj;
  logic [NW:0]   u_minus_v;
  logic [NW-1:0] v_minus_u;
  logic [DW-1:0] g_w;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_diff;
  logic          q_bit;

  assign den_adj   = (in_den == '0) ? DW'(1) : in_den;
  assign u_minus_v = {1'b0, u_r} - {1'b0, v_r};
  assign v_minus_u = v_r - u_r;
  assign g_w       = (u_r[DW-1:0] | v_r[DW-1:0]) << k_r;
  assign rem_sh    = {rem_r, dq_r[NW-1]};
  assign rem_diff  = rem_sh - {1'b0, g_r};
  assign q_bit     = ~rem_diff[DW];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r  <= in_num;
      d_r  <= den_adj;
      nz_r <= (in_num == '0);
      u_r  <= in_num;
      v_r  <= {{(NW-DW){1'b0}}, den_adj};
      k_r  <= '0;
    end else if (cmd.gcd_step) begin
      if (!u_r[0] && !v_r[0]) begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (!u_minus_v[NW]) begin
        u_r <= u_minus_v[NW-1:0];
      end else begin
        v_r <= v_minus_u;
      end
    end

    if (cmd.div_n_init) begin
      g_r   <= g_w;
      dq_r  <= n_r;
      rem_r <= '0;
      cnt_r <= sfr_pkg::DIV_N_STEPS;
    end else if (cmd.div_d_init) begin
      qn_r  <= (dq_r[NW-1:DW] != '0) ? {DW{1'b1}} : dq_r[DW-1:0];
      dq_r  <= {d_r, {(NW-DW){1'b0}}};
      rem_r <= '0;
      cnt_r <= sfr_pkg::DIV_D_STEPS;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
      dq_r  <= {dq_r[NW-2:0], q_bit};
      cnt_r <= cnt_r - 1'b1;
    end

    if (cmd.finish) begin
      out_num_r <= nz_r ? '0 : qn_r;
      out_den_r <= nz_r ? DW'(1) : dq_r[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  assign sts.num_zero = nz_r;
  assign sts.gcd_done = (u_r == '0) || (v_r == '0);
  assign sts.div_done = (cnt_r == '0);

  assign out_valid = out_valid_r;
  assign out_num   = out_num_r;
  assign out_den   = out_den_r;

endmodule
`default_nettype wire

[rtl/sfr_checker.sv]
// Port-level checker for the fraction reducer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sfr_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      out_valid,
  input wire logic [sfr_pkg::DEN_W-1:0] out_num_out,
  input wire logic [sfr_pkg::DEN_W-1:0] out_den_out
);

  // a taken transaction keeps the block busy until its result
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after accepted transaction");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on consecutive cycles");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_den_out != '0))
    else $error("zero denominator in result");

  a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_num_out == '0)) |-> (out_den_out == sfr_pkg::DEN_W'(1)))
    else $error("zero numerator without unit denominator");

endmodule

bind saturating_fraction_reducer sfr_checker u_sfr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_num_out (out_num_out),
  .out_den_out (out_den_out)
);
`default_nettype wire
